@@ hdl/cwcv_pkg.sv @@
package cwcv_pkg;

	localparam int CHAN_W      = 16;
	localparam int NUM_CHANS   = 4;
	localparam int NUM_CLASSES = 5;
	localparam int CLASS_W     = 3;
	localparam int RANK_W      = 3;
	localparam int COUNT_W     = 7;

	typedef logic [CHAN_W-1:0]  chan_t;
	typedef logic [CLASS_W-1:0] class_t;
	typedef logic [RANK_W-1:0]  rank_t;
	typedef logic [COUNT_W-1:0] count_t;

	localparam class_t CLASS_GREEN   = 3'd0;
	localparam class_t CLASS_YELLOW  = 3'd1;
	localparam class_t CLASS_ORANGE  = 3'd2;
	localparam class_t CLASS_RED     = 3'd3;
	localparam class_t CLASS_NOTHING = 3'd4;

	localparam count_t SAMPLE_COUNT_RESET = 7'd10;

	// Channel order inside a box: red, green, blue, clear.
	// Lower bound inclusive, upper bound exclusive.
	localparam chan_t BOX_LO [NUM_CLASSES][NUM_CHANS] = '{
		'{16'd65, 16'd76, 16'd33, 16'd62},
		'{16'd40, 16'd60, 16'd21, 16'd48},
		'{16'd43, 16'd70, 16'd28, 16'd71},
		'{16'd65, 16'd89, 16'd44, 16'd96},
		'{16'd84, 16'd90, 16'd50, 16'd99}
	};
	localparam chan_t BOX_HI [NUM_CLASSES][NUM_CHANS] = '{
		'{16'd75,  16'd87,  16'd38, 16'd72},
		'{16'd47,  16'd71,  16'd25, 16'd56},
		'{16'd53,  16'd84,  16'd33, 16'd84},
		'{16'd75,  16'd106, 16'd53, 16'd112},
		'{16'd102, 16'd107, 16'd61, 16'd116}
	};

	typedef struct packed {
		count_t winning_votes;
		class_t majority_class;
	} result_t;

endpackage

@@ hdl/cwcv_classify.sv @@
module cwcv_classify (
	input  cwcv_pkg::chan_t  red_period,
	input  cwcv_pkg::chan_t  green_period,
	input  cwcv_pkg::chan_t  blue_period,
	input  cwcv_pkg::chan_t  clear_period,
	output cwcv_pkg::class_t color_class
);

	cwcv_pkg::chan_t ch [cwcv_pkg::NUM_CHANS];
	logic [cwcv_pkg::NUM_CLASSES-1:0] hit;

	assign ch[0] = red_period;
	assign ch[1] = green_period;
	assign ch[2] = blue_period;
	assign ch[3] = clear_period;

	always_comb begin
		for (int b = 0; b < cwcv_pkg::NUM_CLASSES; b++) begin
			hit[b] = 1'b1;
			for (int c = 0; c < cwcv_pkg::NUM_CHANS; c++) begin
				if (ch[c] < cwcv_pkg::BOX_LO[b][c] || ch[c] >= cwcv_pkg::BOX_HI[b][c]) begin
					hit[b] = 1'b0;
				end
			end
		end
	end

	// Earlier box wins; violet maps onto nothing like a miss does.
	always_comb begin
		color_class = cwcv_pkg::CLASS_NOTHING;
		for (int b = cwcv_pkg::NUM_CLASSES - 1; b >= 0; b--) begin
			if (hit[b]) begin
				color_class = cwcv_pkg::class_t'(b);
			end
		end
	end

endmodule

@@ hdl/cwcv_vote.sv @@
module cwcv_vote #(
	parameter int MAX_SAMPLES = 64
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  cwcv_pkg::count_t   cfg_data,
	input  logic               in_valid,
	output logic               in_ready,
	input  cwcv_pkg::class_t   in_class,
	output logic               out_valid,
	input  logic               out_ready,
	output cwcv_pkg::result_t  out_result
);

	localparam int VW = $clog2(MAX_SAMPLES + 1);
	localparam int CW = (VW > cwcv_pkg::COUNT_W) ? VW : cwcv_pkg::COUNT_W;

	cwcv_pkg::count_t  sample_count_q;
	logic [VW-1:0]     votes_q [cwcv_pkg::NUM_CLASSES];
	cwcv_pkg::rank_t   rank_q  [cwcv_pkg::NUM_CLASSES];
	logic [cwcv_pkg::NUM_CLASSES-1:0] seen_q;
	cwcv_pkg::rank_t   next_rank_q;
	logic [VW-1:0]     taken_q;
	logic              out_valid_q;
	cwcv_pkg::result_t out_result_q;

	logic [VW-1:0]     votes_n [cwcv_pkg::NUM_CLASSES];
	cwcv_pkg::rank_t   rank_n  [cwcv_pkg::NUM_CLASSES];
	logic [cwcv_pkg::NUM_CLASSES-1:0] seen_n;
	logic [CW-1:0]     run_len;
	logic [CW-1:0]     taken_inc;
	logic              is_last;
	logic              out_free;
	logic              take;
	cwcv_pkg::class_t  best_c;
	logic [CW-1:0]     best_v;
	cwcv_pkg::rank_t   best_r;

	always_comb begin
		if (sample_count_q == '0) begin
			run_len = CW'(1);
		end else if (CW'(sample_count_q) > CW'(MAX_SAMPLES)) begin
			run_len = CW'(MAX_SAMPLES);
		end else begin
			run_len = CW'(sample_count_q);
		end
	end

	assign taken_inc = CW'(taken_q) + CW'(1);
	assign is_last   = taken_inc >= run_len;
	assign out_free  = !out_valid_q || out_ready;
	assign in_ready  = !is_last || out_free;
	assign take      = in_valid && in_ready;

	always_comb begin
		for (int k = 0; k < cwcv_pkg::NUM_CLASSES; k++) begin
			votes_n[k] = votes_q[k];
			rank_n[k]  = rank_q[k];
			seen_n[k]  = seen_q[k];
			if (in_class == cwcv_pkg::class_t'(k)) begin
				votes_n[k] = votes_q[k] + VW'(1);
				seen_n[k]  = 1'b1;
				if (!seen_q[k]) begin
					rank_n[k] = next_rank_q;
				end
			end
		end
	end

	// Most votes wins; on a tie the class seen first in the run wins.
	always_comb begin
		best_c = cwcv_pkg::CLASS_NOTHING;
		best_v = '0;
		best_r = '0;
		for (int k = 0; k < cwcv_pkg::NUM_CLASSES; k++) begin
			if (seen_n[k] && (CW'(votes_n[k]) > best_v ||
			    (CW'(votes_n[k]) == best_v && rank_n[k] < best_r))) begin
				best_c = cwcv_pkg::class_t'(k);
				best_v = CW'(votes_n[k]);
				best_r = rank_n[k];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sample_count_q <= cwcv_pkg::SAMPLE_COUNT_RESET;
			for (int k = 0; k < cwcv_pkg::NUM_CLASSES; k++) begin
				votes_q[k] <= '0;
				rank_q[k]  <= '0;
			end
			seen_q      <= '0;
			next_rank_q <= '0;
			taken_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				sample_count_q <= cfg_data;
			end
			if (take && is_last) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (take) begin
				if (is_last) begin
					for (int k = 0; k < cwcv_pkg::NUM_CLASSES; k++) begin
						votes_q[k] <= '0;
						rank_q[k]  <= '0;
					end
					seen_q      <= '0;
					next_rank_q <= '0;
					taken_q     <= '0;
				end else begin
					for (int k = 0; k < cwcv_pkg::NUM_CLASSES; k++) begin
						votes_q[k] <= votes_n[k];
						rank_q[k]  <= rank_n[k];
					end
					seen_q  <= seen_n;
					taken_q <= taken_inc[VW-1:0];
					if (!seen_q[in_class]) begin
						next_rank_q <= next_rank_q + cwcv_pkg::rank_t'(1);
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take && is_last) begin
			out_result_q.majority_class <= best_c;
			out_result_q.winning_votes  <= best_v[cwcv_pkg::COUNT_W-1:0];
		end
	end

	assign out_valid  = out_valid_q;
	assign out_result = out_result_q;

endmodule

@@ hdl/color_window_classifier_vote.sv @@
// Majority vote over colour-sensor readings. Each reading (red, green, blue and
// clear pulse periods) is classified against fixed window boxes as green,
// yellow, orange, red or nothing, and counted. The reading that completes a run
// of sample_count readings (0 acts as 1, values above MAX_SAMPLES saturate)
// yields one result: the class with the most votes, ties going to the class
// that appeared first, and its vote count; the run then starts over. One
// reading is accepted every clock unless the input stalls; a reading passes
// the box-compare register and then the vote/result register before the
// result of its run shows. The input stalls only while a completing reading
// waits in the compare register for the previous result to be taken.
// The configuration channel is always ready; the user must write it only
// while the block is idle, as the block itself does not enforce this.
module color_window_classifier_vote #(
	parameter int MAX_SAMPLES = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [6:0]  cfg_data,      // sample_count
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [63:0] s_axis_tdata,  // red_period, green_period, blue_period, clear_period
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [15:0] m_axis_tdata   // majority_class[2:0], winning_votes[9:3], zero pad
);

	cwcv_pkg::class_t  class_in;
	cwcv_pkg::class_t  class_s1;
	logic              valid_s1;
	logic              vote_ready;
	cwcv_pkg::result_t result;

	cwcv_classify u_classify (
		.red_period   (s_axis_tdata[15:0]),
		.green_period (s_axis_tdata[31:16]),
		.blue_period  (s_axis_tdata[47:32]),
		.clear_period (s_axis_tdata[63:48]),
		.color_class  (class_in)
	);

	assign s_axis_tready = !valid_s1 || vote_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			class_s1 <= class_in;
		end
	end

	assign cfg_ready = 1'b1;

	cwcv_vote #(
		.MAX_SAMPLES (MAX_SAMPLES)
	) u_vote (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_valid),
		.cfg_data   (cfg_data),
		.in_valid   (valid_s1),
		.in_ready   (vote_ready),
		.in_class   (class_s1),
		.out_valid  (m_axis_tvalid),
		.out_ready  (m_axis_tready),
		.out_result (result)
	);

	assign m_axis_tdata = {6'd0, result.winning_votes, result.majority_class};

	a_class_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[2:0] <= cwcv_pkg::CLASS_NOTHING)
		else $error("result class out of range");

	a_votes_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && (MAX_SAMPLES < 128) |-> m_axis_tdata[9:3] != 7'd0)
		else $error("winning class holds no votes");

	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !vote_ready |=> valid_s1 && $stable(class_s1))
		else $error("stalled reading lost");

	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		!m_axis_tvalid ##1 m_axis_tvalid |-> $past(valid_s1 && vote_ready))
		else $error("result without a completing reading");

endmodule
